// ===== design/wcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_pkg
// Shared types and constants of the cellular crack mask block.
// ----------------------------------------------------------------------------
package wcm_pkg;

    // hash chain multipliers
    localparam logic [63:0] HASH_K1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_K2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] HASH_K3 = 64'h165667B19E3779F9;
    localparam logic [63:0] MIX_K1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_K2  = 64'h94D049BB133111EB;

    // feature point placement, Q0.16
    localparam logic [20:0] FEAT_MAX  = 21'h1FFFFF;
    localparam logic [15:0] FEAT_BASE = 16'd9830;
    localparam logic [15:0] FEAT_SPAN = 16'd45875;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam int          NB_COUNT = 27;
    localparam int          MAX_INFL = 3;
    localparam int          PIPE_LEN = 15;
    localparam int          ROOT_STEPS = 18;

    // register indexes
    typedef enum logic [1:0] {
        REG_SEED  = 2'd0,
        REG_FREQ  = 2'd1,
        REG_INVW  = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    // scaled point: integer cell and fraction per axis
    typedef struct packed {
        logic [31:0] cell_x;
        logic [31:0] cell_y;
        logic [31:0] cell_z;
        logic [15:0] frac_x;
        logic [15:0] frac_y;
        logic [15:0] frac_z;
    } t_pt;

    // per-candidate side data that rides along the hash pipeline
    typedef struct packed {
        logic        first;
        logic        last;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fz;
        logic [1:0]  ix;
        logic [1:0]  iy;
        logic [1:0]  iz;
    } t_side;

    // nearest and second nearest squared distances
    typedef struct packed {
        logic [35:0] best1;
        logic [35:0] best2;
    } t_dist;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_ROOT,
        FS_SCALE,
        FS_EDGE
    } t_fin_st;

endpackage

// ===== design/wcm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_front
// Accepts sample points, scales them by the frequency and splits cell/fraction.
// ----------------------------------------------------------------------------
module wcm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_pos_x,
    input  logic [31:0]     i_pos_y,
    input  logic [31:0]     i_pos_z,
    input  logic [23:0]     i_freq,
    output wcm_pkg::t_pt    o_pt,
    output logic            o_pt_v,
    input  logic            i_pt_rdy
);
    logic                r_v;
    wcm_pkg::t_pt        r_pt;
    wcm_pkg::t_pt        n_pt;
    logic signed [56:0]  w_px, w_py, w_pz;

    // scale: Q16.16 times Q8.16, exact
    assign w_px = $signed(i_pos_x) * $signed({1'b0, i_freq});
    assign w_py = $signed(i_pos_y) * $signed({1'b0, i_freq});
    assign w_pz = $signed(i_pos_z) * $signed({1'b0, i_freq});

    always_comb begin
        n_pt.cell_x = {{7{w_px[56]}}, w_px[56:32]};
        n_pt.cell_y = {{7{w_py[56]}}, w_py[56:32]};
        n_pt.cell_z = {{7{w_pz[56]}}, w_pz[56:32]};
        n_pt.frac_x = w_px[31:16];
        n_pt.frac_y = w_py[31:16];
        n_pt.frac_z = w_pz[31:16];
    end

    assign o_ready = !r_v || i_pt_rdy;
    assign o_pt    = r_pt;
    assign o_pt_v  = r_v;

    // hold the scaled point until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pt <= n_pt;
        end
    end

endmodule

// ===== design/wcm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_fifo
// Two-entry queue of scaled points between the front and the back.
// ----------------------------------------------------------------------------
module wcm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wcm_pkg::t_pt    i_pt,
    input  logic            i_push_v,
    output logic            o_push_rdy,
    output wcm_pkg::t_pt    o_pt,
    output logic            o_pt_v,
    input  logic            i_pop
);
    wcm_pkg::t_pt  r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_push_rdy = (r_cnt != 2'd2);
    assign o_pt_v     = (r_cnt != 2'd0);
    assign o_pt       = r_mem[r_rp];
    assign w_push     = i_push_v && o_push_rdy;
    assign w_pop      = i_pop && o_pt_v;

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_pt;
        end
    end

endmodule

// ===== design/wcm_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_mul64
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module wcm_mul64 (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_k,
    output logic [63:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] w_lh;
    logic [63:0] w_hl;
    logic [31:0] w_mid;

    assign w_lh  = i_a[31:0] * i_k[63:32];
    assign w_hl  = i_a[63:32] * i_k[31:0];
    assign w_mid = r_lh + r_hl;

    // partial products, then combine
    always_ff @(posedge i_clk) begin
        r_ll <= i_a[31:0] * i_k[31:0];
        r_lh <= w_lh[31:0];
        r_hl <= w_hl[31:0];
        o_p  <= r_ll + {w_mid, 32'h0};
    end

endmodule

// ===== design/wcm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_back
// Walks the 27 neighbour cells, hashes each one, measures the squared
// distance to its feature point and keeps the two smallest.
// ----------------------------------------------------------------------------
module wcm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wcm_pkg::t_pt    i_pt,
    input  logic            i_pt_v,
    output logic            o_pop,
    input  logic [63:0]     i_seed,
    output wcm_pkg::t_dist  o_fin,
    output logic            o_fin_v,
    input  logic            i_fin_take,
    input  logic            i_done
);
    localparam int LAST = wcm_pkg::PIPE_LEN - 1;

    logic [4:0]      r_nb;
    logic [1:0]      r_ix, r_iy, r_iz;
    logic [1:0]      r_cnt;
    logic            w_issue;
    logic            w_start;
    logic            w_last;
    wcm_pkg::t_side  n_side;
    wcm_pkg::t_side  r_side [wcm_pkg::PIPE_LEN];
    logic            r_sv   [wcm_pkg::PIPE_LEN];

    logic [63:0]     w_h1, w_h2, w_h3, w_h4, w_h5, w_hf;
    logic [36:0]     r_pp_x, r_pp_y, r_pp_z;
    logic [15:0]     r_ft_x, r_ft_y, r_ft_z;
    logic [33:0]     r_sq_x, r_sq_y, r_sq_z;
    logic [35:0]     r_d2;
    logic [33:0]     w_sq_x, w_sq_y, w_sq_z;
    logic [35:0]     r_b1, r_b2, n_b1, n_b2;
    wcm_pkg::t_dist  r_fin;
    logic            r_fin_v;

    // divide by 2^21-1 with one correction, then place in the cell
    function automatic logic [15:0] feat(input logic [36:0] p);
        logic [15:0] q0;
        logic [21:0] rem;
        q0  = p[36:21];
        rem = {1'b0, p[20:0]} + {6'h0, q0};
        if (rem >= {1'b0, wcm_pkg::FEAT_MAX}) begin
            q0 = q0 + 16'd1;
        end
        return wcm_pkg::FEAT_BASE + q0;
    endfunction

    // offset to the feature point and its square
    function automatic logic [33:0] sq(input logic [15:0] ft, input logic [15:0] fr,
                                       input logic [1:0] idx);
        logic signed [18:0] off;
        logic signed [37:0] prod;
        off = $signed({3'b0, ft}) - $signed({3'b0, fr});
        unique case (idx)
            2'd0:    off = off - 19'sd65536;
            2'd2:    off = off + 19'sd65536;
            default: off = off;
        endcase
        prod = off * off;
        return prod[33:0];
    endfunction

    // sequence the neighbourhood, z outermost and x innermost
    assign w_last  = (r_nb == 5'(wcm_pkg::NB_COUNT - 1));
    assign w_start = (r_nb == 5'd0);
    assign w_issue = i_pt_v && (!w_start || r_cnt != 2'(wcm_pkg::MAX_INFL));
    assign o_pop   = w_issue && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb  <= 5'd0;
            r_ix  <= 2'd0;
            r_iy  <= 2'd0;
            r_iz  <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            if (w_issue) begin
                r_nb <= w_last ? 5'd0 : r_nb + 5'd1;
                r_ix <= (r_ix == 2'd2) ? 2'd0 : r_ix + 2'd1;
                if (r_ix == 2'd2) begin
                    r_iy <= (r_iy == 2'd2) ? 2'd0 : r_iy + 2'd1;
                    if (r_iy == 2'd2) begin
                        r_iz <= (r_iz == 2'd2) ? 2'd0 : r_iz + 2'd1;
                    end
                end
            end
            r_cnt <= r_cnt + 2'(w_issue && w_start) - 2'(i_done);
        end
    end

    always_comb begin
        n_side.first = w_start;
        n_side.last  = w_last;
        n_side.cx    = i_pt.cell_x + 32'(r_ix) - 32'd1;
        n_side.cy    = i_pt.cell_y + 32'(r_iy) - 32'd1;
        n_side.cz    = i_pt.cell_z + 32'(r_iz) - 32'd1;
        n_side.fx    = i_pt.frac_x;
        n_side.fy    = i_pt.frac_y;
        n_side.fz    = i_pt.frac_z;
        n_side.ix    = r_ix;
        n_side.iy    = r_iy;
        n_side.iz    = r_iz;
    end

    // shift candidate tags along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wcm_pkg::PIPE_LEN; i++) begin
                r_sv[i] <= 1'b0;
            end
        end else begin
            r_sv[0] <= w_issue;
            for (int i = 1; i < wcm_pkg::PIPE_LEN; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int i = 1; i < wcm_pkg::PIPE_LEN; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // hash chain, two stages per multiply
    wcm_mul64 u_m1 (.i_clk(i_clk), .i_a(i_seed ^ {32'h0, r_side[0].cx}),
                    .i_k(wcm_pkg::HASH_K1), .o_p(w_h1));
    wcm_mul64 u_m2 (.i_clk(i_clk), .i_a(w_h1 ^ {32'h0, r_side[2].cy}),
                    .i_k(wcm_pkg::HASH_K2), .o_p(w_h2));
    wcm_mul64 u_m3 (.i_clk(i_clk), .i_a(w_h2 ^ {32'h0, r_side[4].cz}),
                    .i_k(wcm_pkg::HASH_K3), .o_p(w_h3));
    wcm_mul64 u_m4 (.i_clk(i_clk), .i_a(w_h3 ^ (w_h3 >> 30)),
                    .i_k(wcm_pkg::MIX_K1), .o_p(w_h4));
    wcm_mul64 u_m5 (.i_clk(i_clk), .i_a(w_h4 ^ (w_h4 >> 27)),
                    .i_k(wcm_pkg::MIX_K2), .o_p(w_h5));

    assign w_hf = w_h5 ^ (w_h5 >> 31);

    assign w_sq_x = sq(r_ft_x, r_side[12].fx, r_side[12].ix);
    assign w_sq_y = sq(r_ft_y, r_side[12].fy, r_side[12].iy);
    assign w_sq_z = sq(r_ft_z, r_side[12].fz, r_side[12].iz);

    // feature coordinates, squares and squared distance
    always_ff @(posedge i_clk) begin
        r_pp_x <= {16'h0, w_hf[20:0]}  * {21'h0, wcm_pkg::FEAT_SPAN};
        r_pp_y <= {16'h0, w_hf[41:21]} * {21'h0, wcm_pkg::FEAT_SPAN};
        r_pp_z <= {16'h0, w_hf[62:42]} * {21'h0, wcm_pkg::FEAT_SPAN};
        r_ft_x <= feat(r_pp_x);
        r_ft_y <= feat(r_pp_y);
        r_ft_z <= feat(r_pp_z);
        r_sq_x <= w_sq_x;
        r_sq_y <= w_sq_y;
        r_sq_z <= w_sq_z;
        r_d2   <= {2'b0, r_sq_x} + {2'b0, r_sq_y} + {2'b0, r_sq_z};
    end

    // keep nearest and second nearest; ties leave the nearest in place
    always_comb begin
        n_b1 = r_b1;
        n_b2 = r_b2;
        if (r_side[LAST].first) begin
            n_b1 = r_d2;
            n_b2 = '1;
        end else if (r_d2 < r_b1) begin
            n_b2 = r_b1;
            n_b1 = r_d2;
        end else if (r_d2 < r_b2) begin
            n_b2 = r_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv[LAST]) begin
            r_b1 <= n_b1;
            r_b2 <= n_b2;
        end
        if (r_sv[LAST] && r_side[LAST].last) begin
            r_fin.best1 <= n_b1;
            r_fin.best2 <= n_b2;
        end
    end

    // hand the finished pair to the finisher
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (r_sv[LAST] && r_side[LAST].last) begin
            r_fin_v <= 1'b1;
        end else if (i_fin_take) begin
            r_fin_v <= 1'b0;
        end
    end

    assign o_fin   = r_fin;
    assign o_fin_v = r_fin_v;

endmodule

// ===== design/wcm_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_finish
// Square roots of F1 and F2, edge scaling, clamp and the output register.
// ----------------------------------------------------------------------------
module wcm_finish (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wcm_pkg::t_dist  i_fin,
    input  logic            i_fin_v,
    output logic            o_fin_take,
    input  logic [23:0]     i_inv_width,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [16:0]     o_crack_mask
);
    wcm_pkg::t_fin_st r_st, n_st;
    logic [35:0]      r_v1, r_v2, r_q1, r_q2, r_bit;
    logic [35:0]      n_v1, n_v2, n_q1, n_q2;
    logic [4:0]       r_step;
    logic [41:0]      r_prod;
    logic [17:0]      w_diff;
    logic [27:0]      w_edge;
    logic [16:0]      w_mask;
    logic             r_ov;
    logic             w_out_free;
    logic             w_root_end;
    logic             w_load_out;

    // one step of the bitwise root
    function automatic logic [71:0] root_step(input logic [35:0] v, input logic [35:0] q,
                                              input logic [35:0] b);
        logic [35:0] t;
        t = q + b;
        if (v >= t) begin
            return {v - t, (q >> 1) + b};
        end
        return {v, q >> 1};
    endfunction

    assign {n_v1, n_q1} = root_step(r_v1, r_q1, r_bit);
    assign {n_v2, n_q2} = root_step(r_v2, r_q2, r_bit);

    assign w_out_free = !r_ov || i_ready;
    assign w_root_end = (r_step == 5'(wcm_pkg::ROOT_STEPS - 1));
    assign w_diff     = r_q2[17:0] - r_q1[17:0];
    assign w_edge     = (r_prod[41:14] > 28'(wcm_pkg::ONE_Q16)) ? 28'(wcm_pkg::ONE_Q16)
                                                                : r_prod[41:14];
    assign w_mask     = wcm_pkg::ONE_Q16 - w_edge[16:0];

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            wcm_pkg::FS_IDLE:  if (i_fin_v) n_st = wcm_pkg::FS_ROOT;
            wcm_pkg::FS_ROOT:  if (w_root_end) n_st = wcm_pkg::FS_SCALE;
            wcm_pkg::FS_SCALE: n_st = wcm_pkg::FS_EDGE;
            wcm_pkg::FS_EDGE:  if (w_out_free) n_st = wcm_pkg::FS_IDLE;
            default:           n_st = wcm_pkg::FS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_fin_take = 1'b0;
        w_load_out = 1'b0;
        unique case (r_st)
            wcm_pkg::FS_IDLE: o_fin_take = i_fin_v;
            wcm_pkg::FS_EDGE: w_load_out = w_out_free;
            default: begin
                o_fin_take = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= wcm_pkg::FS_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath: load, iterate the roots, scale, drive the output
    always_ff @(posedge i_clk) begin
        if (o_fin_take) begin
            r_v1   <= i_fin.best1;
            r_v2   <= i_fin.best2;
            r_q1   <= '0;
            r_q2   <= '0;
            r_bit  <= 36'h1 << 34;
            r_step <= 5'd0;
        end else if (r_st == wcm_pkg::FS_ROOT) begin
            r_v1   <= n_v1;
            r_v2   <= n_v2;
            r_q1   <= n_q1;
            r_q2   <= n_q2;
            r_bit  <= r_bit >> 2;
            r_step <= r_step + 5'd1;
        end
        if (r_st == wcm_pkg::FS_SCALE) begin
            r_prod <= {24'h0, w_diff} * {18'h0, i_inv_width};
        end
        if (w_load_out) begin
            o_crack_mask <= w_mask;
        end
    end

    assign o_valid = r_ov;

endmodule

// ===== design/worley_crack_mask.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worley_crack_mask
// Cellular F2-F1 crack mask of a 3D point in fixed point.
// ----------------------------------------------------------------------------
// A single pipelined hash-and-distance unit visits one of the 27 neighbour
// cells per cycle while a point is waiting and the back part has room; the
// walk of the next point starts while earlier points are still in flight.
// A point passes the scaling register, the queue, the neighbour walk, the
// hash and distance pipeline, a handoff to two 18-step square roots in
// parallel plus scaling, and the output register. Up to three points are in
// the back part at once; the output register holds a result while the next
// points are already being worked on. Registers: seed at byte 0, frequency
// at byte 8, inv_width at byte 16; write only while idle.
// ----------------------------------------------------------------------------
module worley_crack_mask (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [16:0] o_crack_mask,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0]     r_seed;
    logic [23:0]     r_freq;
    logic [23:0]     r_invw;
    wcm_pkg::t_reg_idx w_idx;

    wcm_pkg::t_pt    w_fr_pt, w_q_pt;
    logic            w_fr_v, w_q_rdy, w_q_v, w_pop;
    wcm_pkg::t_dist  w_fin;
    logic            w_fin_v, w_fin_take, w_done;

    assign pready = 1'b1;
    assign w_idx  = wcm_pkg::t_reg_idx'(paddr[4:3]);
    assign w_done = o_valid && i_ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'h0;
            r_freq <= 24'd65536;
            r_invw <= 24'd16384;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                wcm_pkg::REG_SEED: r_seed <= pwdata;
                wcm_pkg::REG_FREQ: r_freq <= pwdata[23:0];
                wcm_pkg::REG_INVW: r_invw <= pwdata[23:0];
                default:           r_seed <= r_seed;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            wcm_pkg::REG_SEED: prdata = r_seed;
            wcm_pkg::REG_FREQ: prdata = {40'h0, r_freq};
            wcm_pkg::REG_INVW: prdata = {40'h0, r_invw};
            default:           prdata = 64'h0;
        endcase
    end

    wcm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_freq(r_freq),
        .o_pt(w_fr_pt), .o_pt_v(w_fr_v), .i_pt_rdy(w_q_rdy)
    );

    wcm_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pt(w_fr_pt), .i_push_v(w_fr_v), .o_push_rdy(w_q_rdy),
        .o_pt(w_q_pt), .o_pt_v(w_q_v), .i_pop(w_pop)
    );

    wcm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pt(w_q_pt), .i_pt_v(w_q_v), .o_pop(w_pop),
        .i_seed(r_seed),
        .o_fin(w_fin), .o_fin_v(w_fin_v), .i_fin_take(w_fin_take),
        .i_done(w_done)
    );

    wcm_finish u_finish (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_fin(w_fin), .i_fin_v(w_fin_v), .o_fin_take(w_fin_take),
        .i_inv_width(r_invw),
        .o_valid(o_valid), .i_ready(i_ready), .o_crack_mask(o_crack_mask)
    );

endmodule

// ===== tb/wcm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_checker
// Watches the point and mask channels of the crack mask block, snoops
// register writes, predicts every mask from the accepted point and compares
// it with the mask beats in order.
// ----------------------------------------------------------------------------
module wcm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [16:0] o_crack_mask,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_masks_pending
);

    logic [63:0] seed_q;
    logic [23:0] freq_q;
    logic [23:0] invw_q;
    logic [16:0] mask_queue[$];

    assign o_masks_pending = mask_queue.size();

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v   = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] hash_cell(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] cz);
        logic [63:0] h;
        h = (seed_q ^ {32'd0, cx}) * wcm_pkg::HASH_K1;
        h = (h ^ {32'd0, cy}) * wcm_pkg::HASH_K2;
        h = (h ^ {32'd0, cz}) * wcm_pkg::HASH_K3;
        h = (h ^ (h >> 30)) * wcm_pkg::MIX_K1;
        h = (h ^ (h >> 27)) * wcm_pkg::MIX_K2;
        return h ^ (h >> 31);
    endfunction

    function automatic longint place_feature(logic [20:0] field);
        longint prod;
        prod = longint'({43'd0, field}) * longint'(wcm_pkg::FEAT_SPAN);
        return longint'(wcm_pkg::FEAT_BASE) + prod / longint'({43'd0, wcm_pkg::FEAT_MAX});
    endfunction

    function automatic logic [16:0] predict_mask(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
        logic [31:0] cell_id[3];
        longint      frac[3];
        logic [31:0] pos[3];
        longint      scaled, ox, oy, oz;
        logic [63:0] h, d2, near1, near2, f1, f2, edge_w;
        pos[0] = px; pos[1] = py; pos[2] = pz;
        for (int a = 0; a < 3; a++) begin
            scaled     = (longint'($signed(pos[a])) * longint'(freq_q)) >>> 16;
            frac[a]    = longint'(scaled[15:0]);
            cell_id[a] = scaled[47:16];
        end
        near1 = '1;
        near2 = '1;
        // walk the 3x3x3 neighborhood, keep the two nearest
        for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    h  = hash_cell(cell_id[0] + 32'(dx), cell_id[1] + 32'(dy),
                                   cell_id[2] + 32'(dz));
                    ox = place_feature(h[20:0]) + dx * 65536 - frac[0];
                    oy = place_feature(h[41:21]) + dy * 65536 - frac[1];
                    oz = place_feature(h[62:42]) + dz * 65536 - frac[2];
                    d2 = ox * ox + oy * oy + oz * oz;
                    if (d2 < near1) begin
                        near2 = near1;
                        near1 = d2;
                    end else if (d2 < near2) begin
                        near2 = d2;
                    end
                end
            end
        end
        f1 = floor_root(near1);
        f2 = floor_root(near2);
        edge_w = (f2 > f1) ? (((f2 - f1) * {40'd0, invw_q}) >> 14) : 64'd0;
        if (edge_w > 64'(wcm_pkg::ONE_Q16)) edge_w = 64'(wcm_pkg::ONE_Q16);
        return wcm_pkg::ONE_Q16 - edge_w[16:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_q <= 64'd0;
            freq_q <= 24'd65536;
            invw_q <= 24'd16384;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (wcm_pkg::t_reg_idx'(paddr[4:3]))
                    wcm_pkg::REG_SEED: seed_q <= pwdata;
                    wcm_pkg::REG_FREQ: freq_q <= pwdata[23:0];
                    wcm_pkg::REG_INVW: invw_q <= pwdata[23:0];
                    default: ;
                endcase
            end
            // predict on each point beat
            if (i_valid && o_ready)
                mask_queue.push_back(predict_mask(i_pos_x, i_pos_y, i_pos_z));
            // compare each mask beat with the oldest prediction
            if (o_valid && i_ready) begin
                if (mask_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected mask %0d", o_crack_mask));
                end else if (o_crack_mask !== mask_queue[0]) begin
                    report_mismatch($sformatf("crack_mask got %0d want %0d",
                                              o_crack_mask, mask_queue[0]));
                    void'(mask_queue.pop_front());
                end else begin
                    void'(mask_queue.pop_front());
                end
            end
        end
    end

endmodule

// ===== tb/tb_worley_crack_mask.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worley_crack_mask
// Drives points and register settings into the crack mask block under
// several idle and stall mixes; the checker predicts and compares masks.
// ----------------------------------------------------------------------------
module tb_worley_crack_mask;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic        o_valid;
    logic        i_ready;
    logic [16:0] o_crack_mask;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int masks_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    worley_crack_mask i_dut (.*);

    wcm_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_pos_x, .i_pos_y, .i_pos_z,
        .o_valid, .i_ready, .o_crack_mask, .psel, .penable, .pwrite, .paddr,
        .pwdata, .pready, .o_fail_count(fail_count), .o_masks_pending(masks_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // stall the mask channel at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(wcm_pkg::t_reg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, wait for every mask, then let the back part of the pipe settle
    task automatic drain_masks();
        i_valid <= 1'b0;
        while (masks_pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        logic ok;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        // hold the beat until accepted
        forever begin
            @(negedge i_clk);
            ok = o_ready;
            @(posedge i_clk);
            if (ok) break;
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0, 1: return $urandom();
            2: return 32'($signed($urandom_range(2097152)) - 1048576);
            default: return {16'($urandom_range(8)) - 16'd4, 16'($urandom())};
        endcase
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_pos_x        = '0;
        i_pos_y        = '0;
        i_pos_z        = '0;
        i_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed points at reset settings: extremes, signs, borders
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'hFFFFFFFF, 32'h00000001, 32'h80000000);
        send_point(32'h00008000, 32'h00008000, 32'h00008000);
        send_point(32'hFFFF0000, 32'h00010000, 32'h0000FFFF);
        send_point(32'h12345678, 32'hEDCBA987, 32'h55555555);
        send_point(32'hAAAAAAAA, 32'h7FFF0000, 32'h00000000);
        drain_masks();

        // extreme settings: top seed, top frequency, a large inv_width
        write_reg(wcm_pkg::REG_SEED, '1);
        write_reg(wcm_pkg::REG_FREQ, 64'hFFFFFF);
        write_reg(wcm_pkg::REG_INVW, 64'd16384000);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h0);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_point(32'h00000100, 32'h00000200, 32'h00000300);
        send_point(32'h0, 32'h0, 32'h0);
        drain_masks();

        // zero frequency, zero width reciprocal, write to an unused index
        write_reg(wcm_pkg::REG_FREQ, 64'd0);
        write_reg(wcm_pkg::REG_INVW, 64'd0);
        write_reg(wcm_pkg::REG_NONE, '1);
        send_point(32'h7FFFFFFF, 32'h12345678, 32'h80000000);
        send_point(32'hDEADBEEF, 32'h0, 32'h1);
        drain_masks();

        // random phases, each with its own settings and idle mix
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(wcm_pkg::REG_SEED, {$urandom(), $urandom()});
            case (phase % 4)
                0: write_reg(wcm_pkg::REG_FREQ, 64'd65536);
                1: write_reg(wcm_pkg::REG_FREQ, 64'($urandom_range(24'hFFFFFF)));
                2: write_reg(wcm_pkg::REG_FREQ, 64'($urandom_range(262144, 1)));
                default: write_reg(wcm_pkg::REG_FREQ, 64'($urandom_range(4096)));
            endcase
            case (phase % 3)
                0: write_reg(wcm_pkg::REG_INVW, 64'($urandom_range(16384000)));
                1: write_reg(wcm_pkg::REG_INVW, 64'hFFFFFF);
                default: write_reg(wcm_pkg::REG_INVW, 64'($urandom_range(131072)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int n = 0; n < 160; n++) begin
                // let the pipe empty fully once mid-phase
                if (phase == 1 && n == 80) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (masks_pending != 0) @(posedge i_clk);
                end
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            drain_masks();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
